/* rtl/lrup_pkg.sv */
// ----------------------------------------------------------------------------
// lrup_pkg
// shared widths, defaults, controller states and command bundle for the lru
// page replacement stack
// ----------------------------------------------------------------------------
package lrup_pkg;

    localparam int FRAMES_DEF = 8;
    localparam int PAGE_W     = 8;
    localparam int CNT_W      = 5;
    localparam int TOT_W      = 32;

    localparam logic [CNT_W-1:0] FRAMES_IN_USE_RST = 5'd8;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } lrup_state_t;

    typedef struct packed {
        logic load_in;
        logic commit;
    } lrup_cmd_t;

endpackage

/* rtl/lru_page_replacement_top.sv */
// ----------------------------------------------------------------------------
// lru_page_replacement_top
// lru page replacement stack: one page reference in, one hit/fault result out
//
// channel  dir  handshake               beat contents
// cfg      in   cfg_valid / cfg_ready   cfg_data = frames_in_use
// in       in   in_valid / in_ready     page, last_reference
// out      out  out_valid / out_ready   fault, victim_valid, victim_page,
//                                       resident_count, fault_total
//
// each reference: ST_IDLE captures the beat, then ST_EXEC writes the parallel
// compare, stack shift and counter update into the result register
// a stalled result holds the block in its update cycle; a new beat is taken
// while the previous result still waits
// reset empties the stack, clears the fault count and sets frames_in_use to 8
// cfg_ready is always high
// ----------------------------------------------------------------------------
module lru_page_replacement_top
#(
    parameter int FRAMES = lrup_pkg::FRAMES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lrup_pkg::CNT_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lrup_pkg::PAGE_W-1:0] page,
    input  logic                        last_reference,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        fault,
    output logic                        victim_valid,
    output logic [lrup_pkg::PAGE_W-1:0] victim_page,
    output logic [lrup_pkg::CNT_W-1:0]  resident_count,
    output logic [lrup_pkg::TOT_W-1:0]  fault_total
);
    import lrup_pkg::*;

    lrup_cmd_t cmd;

    assign cfg_ready = 1'b1;

    lrup_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    lrup_dp
    #(
        .FRAMES (FRAMES)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_valid),
        .cfg_data       (cfg_data),
        .page           (page),
        .last_reference (last_reference),
        .fault          (fault),
        .victim_valid   (victim_valid),
        .victim_page    (victim_page),
        .resident_count (resident_count),
        .fault_total    (fault_total)
    );

endmodule

/* rtl/lrup_ctrl.sv */
// ----------------------------------------------------------------------------
// lrup_ctrl
// sequencer: captures a reference, then commits the stack update and the
// result beat once the output register is free
// ----------------------------------------------------------------------------
module lrup_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lrup_pkg::lrup_cmd_t cmd
);
    import lrup_pkg::*;

    lrup_state_t state_reg;
    lrup_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.load_in    = 1'b0;
        cmd.commit     = 1'b0;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // output register free or being drained this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/lrup_dp.sv */
// ----------------------------------------------------------------------------
// lrup_dp
// recency stack registers, parallel page compare, one-position shift,
// fill and fault counters, frame limit register and result registers
// ----------------------------------------------------------------------------
module lrup_dp
#(
    parameter int FRAMES = lrup_pkg::FRAMES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lrup_pkg::lrup_cmd_t        cmd,
    input  logic                       cfg_we,
    input  logic [lrup_pkg::CNT_W-1:0] cfg_data,
    input  logic [lrup_pkg::PAGE_W-1:0] page,
    input  logic                       last_reference,
    output logic                       fault,
    output logic                       victim_valid,
    output logic [lrup_pkg::PAGE_W-1:0] victim_page,
    output logic [lrup_pkg::CNT_W-1:0] resident_count,
    output logic [lrup_pkg::TOT_W-1:0] fault_total
);
    import lrup_pkg::*;

    localparam int FILL_W = $clog2(FRAMES + 1);
    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam logic [FILL_W-1:0] FRAMES_F = FILL_W'(FRAMES);

    logic [PAGE_W-1:0] stack_reg [FRAMES];
    logic [PAGE_W-1:0] stack_next [FRAMES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [TOT_W-1:0]  faults_reg;
    logic [TOT_W-1:0]  faults_next;
    logic [CNT_W-1:0]  frames_in_use_reg;
    logic [PAGE_W-1:0] page_reg;
    logic              last_reg;

    logic              fault_reg;
    logic              victim_valid_reg;
    logic [PAGE_W-1:0] victim_page_reg;
    logic [CNT_W-1:0]  resident_count_reg;
    logic [TOT_W-1:0]  fault_total_reg;

    logic [FILL_W-1:0] limit;
    logic              hit;
    logic [IDX_W-1:0]  hit_pos;
    logic              evict;
    logic              shift;
    logic [FILL_W-1:0] shift_pos;
    logic [FILL_W-1:0] top_pos;
    logic [FILL_W-1:0] fill_upd;
    logic [TOT_W-1:0]  faults_upd;

    // clamp the frame limit into 1..FRAMES
    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            limit = FILL_W'(1);
        end
        else if (frames_in_use_reg > CNT_W'(FRAMES))
        begin
            limit = FRAMES_F;
        end
        else
        begin
            limit = FILL_W'(frames_in_use_reg);
        end
    end

    // parallel compare against resident entries
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int k = FRAMES - 1; k >= 0; k--)
        begin
            if ((FILL_W'(k) < fill_reg) && (stack_reg[k] == page_reg))
            begin
                hit     = 1'b1;
                hit_pos = IDX_W'(k);
            end
        end
    end

    assign evict     = !hit && (fill_reg >= limit);
    assign shift     = hit || evict;
    assign shift_pos = hit ? FILL_W'(hit_pos) : '0;
    assign top_pos   = fill_reg - FILL_W'(1);
    assign fill_upd  = (!hit && !evict) ? fill_reg + FILL_W'(1) : fill_reg;
    assign faults_upd = (hit || (faults_reg == '1)) ? faults_reg : faults_reg + TOT_W'(1);

    // close the gap and append at the most-recent end
    always_comb
    begin
        for (int k = 0; k < FRAMES; k++)
        begin
            stack_next[k] = stack_reg[k];
            if (shift)
            begin
                if (FILL_W'(k) == top_pos)
                begin
                    stack_next[k] = page_reg;
                end
                else if ((FILL_W'(k) >= shift_pos) && (FILL_W'(k) < top_pos))
                begin
                    stack_next[k] = stack_reg[(k + 1) % FRAMES];
                end
            end
            else if (FILL_W'(k) == fill_reg)
            begin
                stack_next[k] = page_reg;
            end
        end
    end

    always_comb
    begin
        fill_next   = fill_reg;
        faults_next = faults_reg;
        if (cmd.commit)
        begin
            fill_next   = last_reg ? '0 : fill_upd;
            faults_next = last_reg ? '0 : faults_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg          <= '0;
            faults_reg        <= '0;
            frames_in_use_reg <= FRAMES_IN_USE_RST;
        end
        else
        begin
            fill_reg   <= fill_next;
            faults_reg <= faults_next;
            if (cfg_we)
            begin
                frames_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            page_reg <= page;
            last_reg <= last_reference;
        end
        if (cmd.commit)
        begin
            for (int k = 0; k < FRAMES; k++)
            begin
                stack_reg[k] <= stack_next[k];
            end
            fault_reg          <= !hit;
            victim_valid_reg   <= evict;
            victim_page_reg    <= evict ? stack_reg[0] : '0;
            resident_count_reg <= CNT_W'(fill_upd);
            fault_total_reg    <= faults_upd;
        end
    end

    assign fault          = fault_reg;
    assign victim_valid   = victim_valid_reg;
    assign victim_page    = victim_page_reg;
    assign resident_count = resident_count_reg;
    assign fault_total    = fault_total_reg;

endmodule
